/* design/gas_sensor_ratio_calibrator_top_defines.svh */
// Assertion helpers for the checker of the calibrator.
`ifndef GAS_SENSOR_RATIO_CALIBRATOR_TOP_DEFINES_SVH
`define GAS_SENSOR_RATIO_CALIBRATOR_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define GSRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define GSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/gsrc_pkg.sv */
package gsrc_pkg;

    localparam int DEF_MAX_SAMPLES = 64;
    localparam int DEF_ADC_BITS    = 10;

    localparam int LR_W      = 16;
    localparam int CAR_W     = 16;
    localparam int BASE_W    = 24;
    localparam int CREG_W    = 7;
    localparam int RS_W      = 24;
    localparam int RATIO_W   = 16;
    localparam int FRAC_W    = 8;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 24;
    localparam int OUT_DW    = 48;
    localparam int REJ_BIT   = RATIO_W + BASE_W;

    localparam logic [CFG_AW-1:0] REG_LOAD_RES   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CLEAN_AIR  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BASE_DEF   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_BASE_MIN   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_BASE_MAX   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_CALIB_CNT  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_MEAS_CNT   = 3'd6;

    localparam logic [LR_W-1:0]   RST_LOAD_RES  = 16'd2560;
    localparam logic [CAR_W-1:0]  RST_CLEAN_AIR = 16'd2534;
    localparam logic [BASE_W-1:0] RST_BASE_DEF  = 24'd2560;
    localparam logic [BASE_W-1:0] RST_BASE_MIN  = 24'd256;
    localparam logic [BASE_W-1:0] RST_BASE_MAX  = 24'd25600;
    localparam logic [CREG_W-1:0] RST_CALIB_CNT = 7'd50;
    localparam logic [CREG_W-1:0] RST_MEAS_CNT  = 7'd10;

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_CALIB   = 1'b1;

endpackage

/* design/gas_sensor_ratio_calibrator_top.sv */
// Channel    Dir  Fields (lowest bit first)
// s_axis     in   tdata: adc_sample; tuser: op
// m_axis     out  tdata: ratio, base_value, rejected; tuser: kind
// cfg        in   i_cfg_we, i_cfg_addr, i_cfg_data (write only)
//
// Each sample with a nonzero reading goes through one shared restoring divider that
// retires one quotient bit a cycle; a zero reading skips that first division.
// A sample that closes an average runs the divider up to three times.
// The input is not ready while a sample is in work; a stalled output holds its beat,
// and the next sample is taken while it waits.
// Reset is synchronous; it restores the config and control registers, not the datapath ones.
module gas_sensor_ratio_calibrator_top #(
    parameter int MAX_SAMPLES = gsrc_pkg::DEF_MAX_SAMPLES,
    parameter int ADC_BITS    = gsrc_pkg::DEF_ADC_BITS,
    parameter int IN_DW       = ((ADC_BITS + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [IN_DW-1:0]             s_axis_tdata,  // adc_sample
    input  logic                         s_axis_tuser,  // op
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [gsrc_pkg::OUT_DW-1:0]  m_axis_tdata,  // ratio, base_value, rejected
    output logic                         m_axis_tuser,  // kind
    input  logic                         i_cfg_we,
    input  logic [gsrc_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [gsrc_pkg::CFG_DW-1:0]  i_cfg_data
);
    import gsrc_pkg::*;

    localparam int SUM_W  = RS_W + $clog2(MAX_SAMPLES);
    localparam int PROD_W = LR_W + ADC_BITS;
    localparam int DIV_A  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DIV_W  = (DIV_A > RS_W + FRAC_W) ? DIV_A : RS_W + FRAC_W;
    localparam int DCNT_W = $clog2(DIV_W);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W  = (CNT_W > CREG_W) ? CNT_W : CREG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DRS  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DAVG = 3'd4;
    localparam logic [2:0] S_SEL  = 3'd5;
    localparam logic [2:0] S_DOUT = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [ADC_BITS-1:0] FULL = '1;

    logic [LR_W-1:0]    r_load_res;
    logic [CAR_W-1:0]   r_clean_air;
    logic [BASE_W-1:0]  r_base_def, r_base_min, r_base_max;
    logic [CREG_W-1:0]  r_calib_cnt, r_meas_cnt;

    logic [2:0]         r_state, n_state;
    logic [BASE_W-1:0]  r_base, n_base;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_mode, n_mode;
    logic [ADC_BITS-1:0] r_adc, n_adc;
    logic [DIV_W-1:0]   r_quo, n_quo;
    logic [BASE_W-1:0]  r_rem, n_rem;
    logic [BASE_W-1:0]  r_dvs, n_dvs;
    logic [DCNT_W-1:0]  r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [RATIO_W-1:0] r_out_ratio, n_out_ratio;
    logic [BASE_W-1:0]  r_out_base, n_out_base;
    logic               r_out_rej, n_out_rej;

    logic [PROD_W-1:0]  w_prod;
    logic [BASE_W:0]    w_rem_sh;
    logic [BASE_W+1:0]  w_diff;
    logic               w_ge;
    logic [RS_W-1:0]    w_q_sat24;
    logic [RATIO_W-1:0] w_q_sat16;
    logic [SUM_W-1:0]   w_sum_acc;
    logic [CNT_W-1:0]   w_idx_inc;
    logic [CMP_W-1:0]   w_creq;
    logic [CNT_W-1:0]   w_count;
    logic               w_bad;

    assign w_prod    = PROD_W'(r_load_res) * PROD_W'(FULL - r_adc);
    assign w_rem_sh  = {r_rem, r_quo[DIV_W-1]};
    assign w_diff    = {1'b0, w_rem_sh} - {2'b00, r_dvs};
    assign w_ge      = !w_diff[BASE_W+1];
    assign w_q_sat24 = (|r_quo[DIV_W-1:RS_W]) ? '1 : r_quo[RS_W-1:0];
    assign w_q_sat16 = (|r_quo[DIV_W-1:RATIO_W]) ? '1 : r_quo[RATIO_W-1:0];
    assign w_sum_acc = r_sum + SUM_W'(w_q_sat24);
    assign w_idx_inc = r_idx + CNT_W'(1);
    assign w_creq    = CMP_W'(r_mode ? r_calib_cnt : r_meas_cnt);
    assign w_count   = (w_creq == '0) ? CNT_W'(1) :
                       (w_creq > CMP_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) :
                       CNT_W'(w_creq);
    assign w_bad     = (w_q_sat24 < r_base_min) || (w_q_sat24 > r_base_max);

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_mode      = r_mode;
        n_adc       = r_adc;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_ratio = r_out_ratio;
        n_out_base  = r_out_base;
        n_out_rej   = r_out_rej;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_adc = s_axis_tdata[ADC_BITS-1:0];
                    if (s_axis_tuser != r_mode) begin
                        n_mode = s_axis_tuser;
                        n_sum  = '0;
                        n_idx  = '0;
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_rem = '0;
                n_dvs = BASE_W'(r_adc);
                n_cnt = DCNT_W'(DIV_W - 1);
                if (r_adc == '0) begin
                    n_quo   = '0;
                    n_state = S_ACC;
                end else begin
                    n_quo   = DIV_W'(w_prod);
                    n_state = S_DRS;
                end
            end
            S_DRS, S_DAVG, S_DOUT: begin
                n_rem = w_ge ? w_diff[BASE_W-1:0] : w_rem_sh[BASE_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], w_ge};
                n_cnt = r_cnt - DCNT_W'(1);
                if (r_cnt == '0) begin
                    priority if (r_state == S_DRS) begin
                        n_state = S_ACC;
                    end else if (r_state == S_DAVG) begin
                        n_state = S_SEL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ACC: begin
                if (w_idx_inc >= w_count) begin
                    n_sum   = '0;
                    n_idx   = '0;
                    n_quo   = DIV_W'(w_sum_acc);
                    n_dvs   = BASE_W'(w_count);
                    n_rem   = '0;
                    n_cnt   = DCNT_W'(DIV_W - 1);
                    n_state = S_DAVG;
                end else begin
                    n_sum   = w_sum_acc;
                    n_idx   = w_idx_inc;
                    n_state = S_IDLE;
                end
            end
            S_SEL: begin
                n_rem = '0;
                n_cnt = DCNT_W'(DIV_W - 1);
                if (r_mode == MODE_MEASURE) begin
                    if (r_base == '0) begin
                        n_quo   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_quo   = DIV_W'({r_quo[RS_W-1:0], FRAC_W'(0)});
                        n_dvs   = r_base;
                        n_state = S_DOUT;
                    end
                end else begin
                    if (r_clean_air == '0) begin
                        n_quo   = '1;
                        n_state = S_DONE;
                    end else begin
                        n_quo   = DIV_W'({r_quo[RS_W-1:0], FRAC_W'(0)});
                        n_dvs   = BASE_W'(r_clean_air);
                        n_state = S_DOUT;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_mode;
                    if (r_mode == MODE_MEASURE) begin
                        n_out_ratio = w_q_sat16;
                        n_out_base  = r_base;
                        n_out_rej   = 1'b0;
                    end else begin
                        n_base      = w_bad ? r_base_def : w_q_sat24;
                        n_out_ratio = '0;
                        n_out_base  = w_bad ? r_base_def : w_q_sat24;
                        n_out_rej   = w_bad;
                    end
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_res  <= RST_LOAD_RES;
            r_clean_air <= RST_CLEAN_AIR;
            r_base_def  <= RST_BASE_DEF;
            r_base_min  <= RST_BASE_MIN;
            r_base_max  <= RST_BASE_MAX;
            r_calib_cnt <= RST_CALIB_CNT;
            r_meas_cnt  <= RST_MEAS_CNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_LOAD_RES:  r_load_res  <= i_cfg_data[LR_W-1:0];
                REG_CLEAN_AIR: r_clean_air <= i_cfg_data[CAR_W-1:0];
                REG_BASE_DEF:  r_base_def  <= i_cfg_data[BASE_W-1:0];
                REG_BASE_MIN:  r_base_min  <= i_cfg_data[BASE_W-1:0];
                REG_BASE_MAX:  r_base_max  <= i_cfg_data[BASE_W-1:0];
                REG_CALIB_CNT: r_calib_cnt <= i_cfg_data[CREG_W-1:0];
                REG_MEAS_CNT:  r_meas_cnt  <= i_cfg_data[CREG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= RST_BASE_DEF;
            r_sum       <= '0;
            r_idx       <= '0;
            r_mode      <= MODE_MEASURE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adc       <= n_adc;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_dvs       <= n_dvs;
        r_cnt       <= n_cnt;
        r_out_kind  <= n_out_kind;
        r_out_ratio <= n_out_ratio;
        r_out_base  <= n_out_base;
        r_out_rej   <= n_out_rej;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = OUT_DW'({r_out_rej, r_out_base, r_out_ratio});

endmodule

/* design/gsrc_checker.sv */
`include "gas_sensor_ratio_calibrator_top_defines.svh"

module gsrc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [gsrc_pkg::OUT_DW-1:0]  m_axis_tdata,
    input logic                         m_axis_tuser
);
    import gsrc_pkg::*;

    // A held output beat keeps its contents until it is taken.
    `GSRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

    // The sequencer is busy after taking a sample.
    `GSRC_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready straight after a beat")

    // A ratio reading never carries the rejection flag.
    `GSRC_ASSERT_SAME(a_ratio_no_rej, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, !m_axis_tdata[REJ_BIT], "rejection flag on a ratio reading")

    // A calibration result carries a zero ratio.
    `GSRC_ASSERT_SAME(a_calib_no_ratio, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[RATIO_W-1:0] == '0, "ratio set on a calibration result")

    // Nothing leaves the block in the first cycle after reset.
    `GSRC_ASSERT_SAME(a_quiet_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !m_axis_tvalid, "output valid straight after reset")

endmodule

bind gas_sensor_ratio_calibrator_top gsrc_checker u_gsrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/gsrc_scoreboard.sv */
`timescale 1ns / 100ps

module gsrc_scoreboard #(
    parameter int MAX_SAMPLES = gsrc_pkg::DEF_MAX_SAMPLES,
    parameter int ADC_BITS    = gsrc_pkg::DEF_ADC_BITS,
    parameter int IN_DW       = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [IN_DW-1:0]            s_axis_tdata,  // adc_sample
    input  logic                        s_axis_tuser,  // op
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [gsrc_pkg::OUT_DW-1:0] m_axis_tdata,  // ratio, base_value, rejected
    input  logic                        m_axis_tuser,  // kind
    input  logic                        i_cfg_we,
    input  logic [gsrc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [gsrc_pkg::CFG_DW-1:0] i_cfg_data,
    output int                          o_pending,
    output int                          o_mismatches
);
    import gsrc_pkg::*;

    localparam logic KIND_RATIO = 1'b0;
    localparam logic KIND_CALIB = 1'b1;
    localparam logic [63:0] FULL_SCALE = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [63:0] SAT24 = 64'hFF_FFFF;
    localparam logic [63:0] SAT16 = 64'hFFFF;

    typedef struct packed {
        logic               kind;
        logic [RATIO_W-1:0] ratio;
        logic [BASE_W-1:0]  base_value;
        logic               rejected;
    } calib_result_t;

    calib_result_t expected_q[$];

    logic [LR_W-1:0]   cfg_load;
    logic [CAR_W-1:0]  cfg_clean_air;
    logic [BASE_W-1:0] cfg_base_def;
    logic [BASE_W-1:0] cfg_base_min;
    logic [BASE_W-1:0] cfg_base_max;
    logic [CREG_W-1:0] cfg_calib_cnt;
    logic [CREG_W-1:0] cfg_meas_cnt;

    logic [BASE_W-1:0] base_kohm;
    logic [63:0]       acc_kohm;
    int                acc_beats;
    logic              cur_mode;
    int                mismatch_count = 0;

    function automatic logic [63:0] sensor_kohm(input logic [IN_DW-1:0] raw);
        logic [63:0] adc;
        logic [63:0] q;
        adc = 64'(raw) & FULL_SCALE;
        if (adc == 64'd0) begin
            return 64'd0;
        end
        q = (64'(cfg_load) * (FULL_SCALE - adc)) / adc;
        return (q > SAT24) ? SAT24 : q;
    endfunction

    task automatic ingest_sample(input logic op, input logic [IN_DW-1:0] raw);
        int unsigned   span;
        logic [63:0]   avg;
        logic [63:0]   quo;
        logic          bad;
        calib_result_t res;
        if (op != cur_mode) begin
            cur_mode  = op;
            acc_kohm  = 64'd0;
            acc_beats = 0;
        end
        acc_kohm  = acc_kohm + sensor_kohm(raw);
        acc_beats = acc_beats + 1;
        span = (cur_mode == MODE_CALIB) ? cfg_calib_cnt : cfg_meas_cnt;
        if (span == 0) begin
            span = 1;
        end else if (span > MAX_SAMPLES) begin
            span = MAX_SAMPLES;
        end
        if (acc_beats < span) begin
            return;
        end
        avg       = acc_kohm / span;
        acc_kohm  = 64'd0;
        acc_beats = 0;
        if (cur_mode == MODE_MEASURE) begin
            quo = 64'd0;
            if (base_kohm != '0) begin
                quo = (avg << FRAC_W) / 64'(base_kohm);
                if (quo > SAT16) begin
                    quo = SAT16;
                end
            end
            res = '{KIND_RATIO, quo[RATIO_W-1:0], base_kohm, 1'b0};
        end else begin
            if (cfg_clean_air == '0) begin
                quo = SAT24;
            end else begin
                quo = (avg << FRAC_W) / 64'(cfg_clean_air);
            end
            if (quo > SAT24) begin
                quo = SAT24;
            end
            bad = (quo < 64'(cfg_base_min)) || (quo > 64'(cfg_base_max));
            base_kohm = bad ? cfg_base_def : quo[BASE_W-1:0];
            res = '{KIND_CALIB, '0, base_kohm, bad};
        end
        expected_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        calib_result_t want;
        logic [RATIO_W-1:0] got_ratio;
        logic [BASE_W-1:0]  got_base;
        logic               got_rej;
        if (!i_rst_n) begin
            cfg_load      = RST_LOAD_RES;
            cfg_clean_air = RST_CLEAN_AIR;
            cfg_base_def  = RST_BASE_DEF;
            cfg_base_min  = RST_BASE_MIN;
            cfg_base_max  = RST_BASE_MAX;
            cfg_calib_cnt = RST_CALIB_CNT;
            cfg_meas_cnt  = RST_MEAS_CNT;
            base_kohm     = RST_BASE_DEF;
            acc_kohm      = 64'd0;
            acc_beats     = 0;
            cur_mode      = MODE_MEASURE;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_LOAD_RES:  cfg_load      = i_cfg_data[LR_W-1:0];
                    REG_CLEAN_AIR: cfg_clean_air = i_cfg_data[CAR_W-1:0];
                    REG_BASE_DEF:  cfg_base_def  = i_cfg_data[BASE_W-1:0];
                    REG_BASE_MIN:  cfg_base_min  = i_cfg_data[BASE_W-1:0];
                    REG_BASE_MAX:  cfg_base_max  = i_cfg_data[BASE_W-1:0];
                    REG_CALIB_CNT: cfg_calib_cnt = i_cfg_data[CREG_W-1:0];
                    REG_MEAS_CNT:  cfg_meas_cnt  = i_cfg_data[CREG_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_ratio = m_axis_tdata[RATIO_W-1:0];
                got_base  = m_axis_tdata[RATIO_W +: BASE_W];
                got_rej   = m_axis_tdata[REJ_BIT];
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat: kind %0d, ratio %0d, base_value %0d",
                           m_axis_tuser, got_ratio, got_base);
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d",
                               want.kind, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (got_ratio !== want.ratio) begin
                        $error("ratio mismatch: expected %0d, actual %0d",
                               want.ratio, got_ratio);
                        mismatch_count++;
                    end
                    if (got_base !== want.base_value) begin
                        $error("base_value mismatch: expected %0d, actual %0d",
                               want.base_value, got_base);
                        mismatch_count++;
                    end
                    if (got_rej !== want.rejected) begin
                        $error("rejected mismatch: expected %0d, actual %0d",
                               want.rejected, got_rej);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                ingest_sample(s_axis_tuser, s_axis_tdata);
            end
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

/* test/tb_gas_sensor_ratio_calibrator_top.sv */
`timescale 1ns / 100ps

module tb_gas_sensor_ratio_calibrator_top;
    import gsrc_pkg::*;

    localparam int IN_DW       = 16;
    localparam int SETTLE_CYC  = 150;
    localparam int CYCLE_LIMIT = 800000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata = '0;   // adc_sample
    logic              s_axis_tuser = 1'b0; // op
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;        // ratio, base_value, rejected
    logic              m_axis_tuser;        // kind
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    int   pending;
    int   mismatches;
    int   cycle_count = 0;
    logic calm = 1'b0;
    logic [CREG_W-1:0] cur_calib_cnt = RST_CALIB_CNT;
    logic [CREG_W-1:0] cur_meas_cnt  = RST_MEAS_CNT;

    gas_sensor_ratio_calibrator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    gsrc_scoreboard #(.IN_DW(IN_DW)) u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic apply_settings(input logic [LR_W-1:0] load, input logic [CAR_W-1:0] car,
                                  input logic [BASE_W-1:0] bdef, input logic [BASE_W-1:0] bmin,
                                  input logic [BASE_W-1:0] bmax, input logic [CREG_W-1:0] ccnt,
                                  input logic [CREG_W-1:0] mcnt);
        logic [CFG_AW-1:0] addrs [7] = '{REG_LOAD_RES, REG_CLEAN_AIR, REG_BASE_DEF,
                                         REG_BASE_MIN, REG_BASE_MAX, REG_CALIB_CNT,
                                         REG_MEAS_CNT};
        logic [CFG_DW-1:0] vals [7];
        vals = '{CFG_DW'(load), CFG_DW'(car), CFG_DW'(bdef), CFG_DW'(bmin), CFG_DW'(bmax),
                 CFG_DW'(ccnt), CFG_DW'(mcnt)};
        for (int r = 0; r < 7; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= addrs[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we      <= 1'b0;
        cur_calib_cnt = ccnt;
        cur_meas_cnt  = mcnt;
    endtask

    task automatic push_sample(input logic op, input logic [9:0] adc);
        while (!calm && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DW'(adc);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Waits until every expected result has been seen, then lets a sample that closes
    // no average drain from the divider.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items);
        int       sent;
        int       eff;
        int       run_len;
        logic     op;
        logic [9:0] adc;
        sent = 0;
        while (sent < n_items) begin
            op  = $urandom_range(1);
            eff = (op == MODE_CALIB) ? cur_calib_cnt : cur_meas_cnt;
            if (eff == 0) begin
                eff = 1;
            end else if (eff > DEF_MAX_SAMPLES) begin
                eff = DEF_MAX_SAMPLES;
            end
            if ($urandom_range(99) < 80) begin
                run_len = eff;
            end else begin
                run_len = $urandom_range(eff + 2, 1);
            end
            repeat (run_len) begin
                case ($urandom_range(9))
                    0: adc = 10'd0;
                    1: adc = 10'h3FF;
                    2: adc = 10'($urandom_range(4, 1));
                    default: adc = 10'($urandom_range(1023));
                endcase
                push_sample(op, adc);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-sample averages: zero and full-scale readings, ratio saturation,
        // accepted and rejected calibrations.
        apply_settings(16'd2560, 16'd2534, 24'd2560, 24'd256, 24'd25600, 7'd1, 7'd1);
        push_sample(MODE_MEASURE, 10'd0);
        push_sample(MODE_MEASURE, 10'h3FF);
        push_sample(MODE_MEASURE, 10'd1);
        push_sample(MODE_CALIB, 10'd512);
        push_sample(MODE_MEASURE, 10'd600);
        push_sample(MODE_CALIB, 10'd1);
        push_sample(MODE_CALIB, 10'h3FF);
        push_sample(MODE_MEASURE, 10'd300);
        settle();

        // Resistance saturation, a clean-air ratio of zero, counts of 0 and 127.
        apply_settings(16'hFFFF, 16'd0, 24'd1000, 24'd0, 24'hFF_FFFF, 7'd0, 7'd127);
        push_sample(MODE_CALIB, 10'd1);
        settle();
        apply_settings(16'hFFFF, 16'd0, 24'd1000, 24'd0, 24'hFF_FFFF, 7'd0, 7'd0);
        push_sample(MODE_MEASURE, 10'd1);
        settle();

        // Minimum above maximum rejects everything; a zero default then gives R0 of zero.
        apply_settings(16'd5000, 16'd256, 24'd0, 24'd5000, 24'd100, 7'd1, 7'd1);
        push_sample(MODE_CALIB, 10'd100);
        push_sample(MODE_MEASURE, 10'd100);
        settle();

        // Count lowered below the index already reached.
        apply_settings(16'd2560, 16'd2534, 24'd2560, 24'd256, 24'd25600, 7'd3, 7'd5);
        push_sample(MODE_CALIB, 10'd400);
        push_sample(MODE_MEASURE, 10'd200);
        push_sample(MODE_MEASURE, 10'd700);
        push_sample(MODE_MEASURE, 10'd900);
        settle();
        apply_settings(16'd2560, 16'd2534, 24'd2560, 24'd256, 24'd25600, 7'd3, 7'd2);
        push_sample(MODE_MEASURE, 10'd50);
        settle();

        apply_settings(RST_LOAD_RES, RST_CLEAN_AIR, RST_BASE_DEF, RST_BASE_MIN, RST_BASE_MAX,
                       7'd3, 7'd2);
        random_phase(180);
        settle();

        apply_settings(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 7'd127, 7'd64);
        random_phase(140);
        settle();

        apply_settings(16'd0, 16'd1, 24'd0, 24'd0, 24'd0, 7'd1, 7'd1);
        random_phase(120);
        settle();

        for (int ph = 0; ph < 3; ph++) begin
            logic [BASE_W-1:0] bmin;
            logic [BASE_W-1:0] bmax;
            bmin = BASE_W'($urandom_range(4095));
            bmax = ($urandom_range(4) == 0) ? BASE_W'($urandom_range(4095))
                                            : BASE_W'($urandom_range(24'hFF_FFFF));
            apply_settings(LR_W'($urandom_range(16'hFFFF)), CAR_W'($urandom_range(16'hFFFF)),
                           BASE_W'($urandom_range(24'hFF_FFFF)), bmin, bmax,
                           CREG_W'($urandom_range(8)), CREG_W'($urandom_range(8)));
            if (ph == 0) begin
                calm <= 1'b1;
            end
            random_phase(220);
            if (ph == 0) begin
                calm <= 1'b0;
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/gsrc_pkg.sv
design/gas_sensor_ratio_calibrator_top.sv
design/gsrc_checker.sv
test/gsrc_scoreboard.sv
test/tb_gas_sensor_ratio_calibrator_top.sv
